### sv/pidc_pkg.sv
// Shared types and constants for the PI drive controller.
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int MEAS_W  = 24;
    localparam int ERR_W   = MEAS_W + 1;
    localparam int ACC_W   = 32;
    localparam int KDIV_W  = 16;
    localparam int DIV_W   = ERR_W + 16;     // |err| * 65536
    localparam int SUM_W   = DIV_W + 1;
    localparam int CNT_W   = 6;
    localparam int DB_W    = 16;
    localparam int MAXD_W  = 8;
    localparam int DRIVE_W = 9;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 16;

    localparam logic [MODE_W-1:0] MODE_HIGH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOW  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_DEADBAND  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_DRIVE = 2'd1;

    localparam logic [MAXD_W-1:0] MAX_DRIVE_RST = 8'd127;

    typedef struct packed {
        logic load_in;
        logic calc_err;
        logic calc_acc;
        logic div_start;
        logic div_step;
        logic calc_sum;
        logic calc_clamp;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic dead;
        logic out_busy;
    } t_dp_status;

endpackage

### sv/pidc_div.sv
// Restoring divider, one quotient bit per cycle while i_step is asserted.
`timescale 1ns / 1ps

module pidc_div
    import pidc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_start,
    input  logic              i_step,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [KDIV_W-1:0] i_divisor,
    output logic [DIV_W-1:0]  o_quotient
);

    logic [KDIV_W-1:0] r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [KDIV_W-1:0] r_dvsr;
    logic [KDIV_W:0]   shifted;
    logic [KDIV_W+1:0] trial;
    logic              ge;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvsr};
        ge      = ~trial[KDIV_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvsr <= i_divisor;
        end else if (i_step) begin
            // shifted stays below twice the divisor, so the remainder fits
            r_rem <= ge ? trial[KDIV_W-1:0] : shifted[KDIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_quotient = r_quo;

endmodule

### sv/pidc_dp.sv
// Datapath: input capture, error and accumulator, dividers, sum, clamp, output register.
`timescale 1ns / 1ps

module pidc_dp
    import pidc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic                     i_cfg_valid,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [CDAT_W-1:0]        i_cfg_data,
    input  logic signed [MEAS_W-1:0] i_measured,
    input  logic signed [MEAS_W-1:0] i_setpoint,
    input  logic [KDIV_W-1:0]        i_prop_divisor,
    input  logic [KDIV_W-1:0]        i_integ_divisor,
    input  logic [MODE_W-1:0]        i_precision_mode,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [DRIVE_W-1:0] o_drive
);

    logic signed [MEAS_W-1:0]  r_meas;
    logic signed [MEAS_W-1:0]  r_sp;
    logic [KDIV_W-1:0]         r_kp;
    logic [KDIV_W-1:0]         r_ki;
    logic [MODE_W-1:0]         r_mode;
    logic signed [MEAS_W-1:0]  r_last_sp;
    logic signed [ACC_W-1:0]   r_esum;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [DRIVE_W-1:0] r_res;
    logic [DB_W-1:0]           r_deadband;
    logic [MAXD_W-1:0]         r_max_drive;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;

    logic [ERR_W-1:0]          err_mag;
    logic                      dead;
    logic signed [ACC_W:0]     acc_wide;
    logic signed [ACC_W-1:0]   acc_sat;
    logic [ACC_W-1:0]          acc_mag;
    logic [KDIV_W-1:0]         kp_eff;
    logic [KDIV_W-1:0]         ki_eff;
    logic [DIV_W-1:0]          p_quo;
    logic [DIV_W-1:0]          i_quo;
    logic signed [SUM_W-1:0]   p_term;
    logic signed [SUM_W-1:0]   i_term;
    logic [SUM_W-1:0]          sum_mag;
    logic [SUM_W-1:0]          lim;
    logic [SUM_W-1:0]          clip_mag;
    logic [MAXD_W-1:0]         q_mag;

    always_comb begin
        err_mag  = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
        dead     = (!r_err[ERR_W-1] && r_err != '0 && r_mode == MODE_HIGH)
                || (r_err[ERR_W-1] && r_mode == MODE_LOW)
                || (err_mag <= {{(ERR_W-DB_W){1'b0}}, r_deadband});
        acc_wide = {r_esum[ACC_W-1], r_esum}
                 + {{(ACC_W+1-ERR_W){r_err[ERR_W-1]}}, r_err};
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1])
            acc_sat = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_sat = acc_wide[ACC_W-1:0];
        acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        kp_eff   = (r_kp == '0) ? KDIV_W'(1) : r_kp;
        ki_eff   = (r_ki == '0) ? KDIV_W'(1) : r_ki;

        p_term   = r_err[ERR_W-1] ? -$signed({1'b0, p_quo}) : $signed({1'b0, p_quo});
        i_term   = r_acc[ACC_W-1] ? -$signed({1'b0, i_quo}) : $signed({1'b0, i_quo});

        sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        lim      = {{(SUM_W-MAXD_W-8){1'b0}}, r_max_drive, 8'h00};
        clip_mag = (sum_mag > lim) ? lim : sum_mag;
        q_mag    = clip_mag[MAXD_W+7:8];
    end

    pidc_div u_div_p (
        .i_clk      (i_clk),
        .i_start    (i_cmd.div_start),
        .i_step     (i_cmd.div_step),
        .i_dividend ({err_mag, 16'h0000}),
        .i_divisor  (kp_eff),
        .o_quotient (p_quo)
    );

    pidc_div u_div_i (
        .i_clk      (i_clk),
        .i_start    (i_cmd.div_start),
        .i_step     (i_cmd.div_step),
        .i_dividend ({{(DIV_W-ACC_W){1'b0}}, acc_mag}),
        .i_divisor  (ki_eff),
        .o_quotient (i_quo)
    );

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sp   <= '0;
            r_esum      <= '0;
            r_deadband  <= '0;
            r_max_drive <= MAX_DRIVE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DEADBAND:  r_deadband  <= i_cfg_data;
                    CFG_MAX_DRIVE: r_max_drive <= i_cfg_data[MAXD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.calc_err && r_sp != r_last_sp) begin
                r_last_sp <= r_sp;
                r_esum    <= '0;
            end
            if (i_cmd.calc_acc)
                r_esum <= dead ? '0 : acc_sat;
            if (i_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_meas <= i_measured;
            r_sp   <= i_setpoint;
            r_kp   <= i_prop_divisor;
            r_ki   <= i_integ_divisor;
            r_mode <= i_precision_mode;
        end
        if (i_cmd.calc_err)
            r_err <= {r_meas[MEAS_W-1], r_meas} - {r_sp[MEAS_W-1], r_sp};
        if (i_cmd.calc_acc) begin
            r_acc <= acc_sat;
            if (dead)
                r_res <= '0;
        end
        if (i_cmd.calc_sum)
            r_sum <= p_term + (i_term <<< 8);
        if (i_cmd.calc_clamp)
            r_res <= r_sum[SUM_W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        if (i_cmd.out_load)
            r_drive <= r_res;
    end

    assign o_status.dead     = dead;
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_drive           = r_drive;

endmodule

### sv/pidc_ctrl.sv
// Controller state machine: sequences one item through the datapath.
`timescale 1ns / 1ps

module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ERR   = 8'b0000_0010,
        S_ACC   = 8'b0000_0100,
        S_LOAD  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_SUM   = 8'b0010_0000,
        S_CLAMP = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state        = S_ACC;
            end
            S_ACC: begin
                o_cmd.calc_acc = 1'b1;
                n_state        = i_status.dead ? S_DONE : S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_cnt           = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1))
                    n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_state        = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.calc_clamp = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                // wait for room in the output register
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### sv/pi_drive_controller.sv
// PI drive controller with deadband. A computed drive passes through the states ERR, ACC, LOAD,
// the bit-serial division in the two dividers (run side by side), SUM, CLAMP and DONE; when
// the error is in the deadband or on the accepted side, ACC goes straight to DONE with a zero drive.
// One item at a time: a new input transfer is taken only once the last item has left DONE, and DONE
// holds while a result waits on a stalled output; the next input transfer is taken while a result
// waits in the output register. Synchronous active-low reset: accumulator, last setpoint 0.
`timescale 1ns / 1ps

module pi_drive_controller
    import pidc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CIDX_W-1:0]         i_cfg_index,
    input  logic [CDAT_W-1:0]         i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [MEAS_W-1:0]  i_measured,
    input  logic signed [MEAS_W-1:0]  i_setpoint,
    input  logic [KDIV_W-1:0]         i_prop_divisor,
    input  logic [KDIV_W-1:0]         i_integ_divisor,
    input  logic [MODE_W-1:0]         i_precision_mode,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [DRIVE_W-1:0] o_drive
);

    // reset also sets deadband 0, max_drive 127 and clears any pending result

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    pidc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pidc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_measured       (i_measured),
        .i_setpoint       (i_setpoint),
        .i_prop_divisor   (i_prop_divisor),
        .i_integ_divisor  (i_integ_divisor),
        .i_precision_mode (i_precision_mode),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_drive          (o_drive)
    );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the PI drive controller: scoreboard, stimulus and pacing.
`timescale 1ns / 1ps

module tb_top;
    import pidc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_PRECISE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;   // unused code, behaves as precise
    localparam longint ACC_MAX     = 64'sd2147483647;
    localparam longint ACC_MIN     = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     TAIL_CYCLES = 60;

    typedef struct {
        logic signed [MEAS_W-1:0] measured;
        logic signed [MEAS_W-1:0] setpoint;
        logic [KDIV_W-1:0]        prop_div;
        logic [KDIV_W-1:0]        integ_div;
        logic [MODE_W-1:0]        mode;
    } t_drive_req;

    class drive_scoreboard;
        longint                   deadband;
        longint                   max_drive;
        logic [MEAS_W-1:0]        last_sp;
        int                       err_acc;
        logic signed [DRIVE_W-1:0] drive_q[$];
        int n_req, n_zero, n_sat, n_ok, n_err;

        function new();
            deadband  = 0;
            max_drive = longint'(MAX_DRIVE_RST);
            last_sp   = '0;
            err_acc   = 0;
            n_req = 0; n_zero = 0; n_sat = 0; n_ok = 0; n_err = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
            case (idx)
                CFG_DEADBAND:  deadband  = longint'(val);
                CFG_MAX_DRIVE: max_drive = longint'(val[MAXD_W-1:0]);
                default: ;
            endcase
        endfunction

        // Work out the drive for an accepted request and queue it.
        function void note_input(t_drive_req r);
            longint e, mag, acc, kp, ki, pi_sum, lim, q;
            logic signed [DRIVE_W-1:0] d;
            n_req++;
            if (r.setpoint !== last_sp) begin
                last_sp = r.setpoint;
                err_acc = 0;
            end
            e   = longint'(r.measured) - longint'(r.setpoint);
            mag = (e < 0) ? -e : e;
            if ((e > 0 && r.mode == MODE_HIGH) || (e < 0 && r.mode == MODE_LOW) ||
                mag <= deadband) begin
                err_acc = 0;
                d = '0;
                n_zero++;
            end else begin
                acc = longint'(err_acc) + e;
                if (acc > ACC_MAX) begin
                    acc = ACC_MAX;
                    n_sat++;
                end else if (acc < ACC_MIN) begin
                    acc = ACC_MIN;
                    n_sat++;
                end
                err_acc = int'(acc);
                kp = longint'(r.prop_div);
                ki = longint'(r.integ_div);
                if (kp == 0) kp = 1;
                if (ki == 0) ki = 1;
                pi_sum = (e * 65536) / kp + (acc / ki) * 256;
                lim = max_drive * 256;
                if (pi_sum > lim) pi_sum = lim;
                else if (pi_sum < -lim) pi_sum = -lim;
                q = pi_sum / 256;
                d = q[DRIVE_W-1:0];
            end
            drive_q.push_back(d);
        endfunction

        function void check_drive(logic signed [DRIVE_W-1:0] got);
            logic signed [DRIVE_W-1:0] want;
            if (drive_q.size() == 0) begin
                $error("drive: unexpected result, expected none, got %0d", got);
                n_err++;
                return;
            end
            want = drive_q.pop_front();
            if (got !== want) begin
                $error("drive mismatch: expected %0d, got %0d", want, got);
                n_err++;
            end else begin
                n_ok++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_valid      = 1'b0;
    logic [CIDX_W-1:0]         i_cfg_index      = CFG_DEADBAND;
    logic [CDAT_W-1:0]         i_cfg_data       = '0;
    logic                      i_in_valid       = 1'b0;
    logic signed [MEAS_W-1:0]  i_measured       = '0;
    logic signed [MEAS_W-1:0]  i_setpoint       = '0;
    logic [KDIV_W-1:0]         i_prop_divisor   = '0;
    logic [KDIV_W-1:0]         i_integ_divisor  = '0;
    logic [MODE_W-1:0]         i_precision_mode = MODE_PRECISE;
    logic                      i_out_ready      = 1'b0;
    logic                      o_cfg_ready;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [DRIVE_W-1:0] o_drive;

    drive_scoreboard sb = new();
    int in_gap_pct  = 0;
    int out_gap_pct = 0;
    int cycles      = 0;

    pi_drive_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_measured       (i_measured),
        .i_setpoint       (i_setpoint),
        .i_prop_divisor   (i_prop_divisor),
        .i_integ_divisor  (i_integ_divisor),
        .i_precision_mode (i_precision_mode),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive          (o_drive)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= (out_gap_pct == 0) || ($urandom_range(1, 100) > out_gap_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_drive(o_drive);
    end

    function automatic t_drive_req mk(logic signed [MEAS_W-1:0] meas,
                                      logic signed [MEAS_W-1:0] sp,
                                      logic [KDIV_W-1:0] kp, logic [KDIV_W-1:0] ki,
                                      logic [MODE_W-1:0] mode);
        t_drive_req r;
        r.measured  = meas;
        r.setpoint  = sp;
        r.prop_div  = kp;
        r.integ_div = ki;
        r.mode      = mode;
        return r;
    endfunction

    // Valid stays up between back-to-back requests; it only drops during a gap.
    task automatic send_req(input t_drive_req r);
        @(negedge i_clk);
        while (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_measured       <= r.measured;
        i_setpoint       <= r.setpoint;
        i_prop_divisor   <= r.prop_div;
        i_integ_divisor  <= r.integ_div;
        i_precision_mode <= r.mode;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_input(r);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait for every outstanding drive value.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KDIV_W-1:0] pick_gain();
        logic [KDIV_W-1:0] g;
        case ($urandom_range(0, 9))
            0:       g = '0;
            1, 2, 3: g = KDIV_W'($urandom_range(1, 1024));
            4:       g = '1;
            default: g = KDIV_W'($urandom);
        endcase
        return g;
    endfunction

    function automatic longint pick_offset();
        longint mag;
        case ($urandom_range(0, 3))
            0:       mag = longint'($urandom_range(0, 16));
            1:       mag = longint'($urandom_range(0, 1200));
            2:       mag = longint'($urandom_range(0, 70000));
            default: mag = longint'($urandom_range(0, 16777215));
        endcase
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        logic [MODE_W-1:0] m;
        m = MODE_W'($urandom_range(0, 3));
        return m;
    endfunction

    // Mostly runs of requests at one setpoint, as a closed loop would produce,
    // plus the odd long run far off target to drive the accumulator into saturation.
    task automatic run_random(input int n_items, input bit windup_first);
        int sent, len, kind;
        bit dir;
        longint off, m;
        logic signed [MEAS_W-1:0] sp, meas;
        logic [KDIV_W-1:0] kp, ki;
        logic [MODE_W-1:0] mode;
        sent = 0;
        while (sent < n_items) begin
            kind = (windup_first && sent == 0) ? 0 : int'($urandom_range(0, 99));
            kp = pick_gain();
            ki = pick_gain();
            if (kind < 2) begin
                dir  = 1'($urandom_range(0, 1));
                mode = $urandom_range(0, 1) ? MODE_PRECISE : MODE_SPARE;
                for (int k = 0; k < 135; k++) begin
                    sp   = dir ? 24'sh7FFFFF - MEAS_W'($urandom_range(0, 8))
                               : 24'sh800000 + 24'sd4;
                    meas = dir ? 24'sh800000 + MEAS_W'($urandom_range(0, 1000))
                               : 24'sh7FFFFF - MEAS_W'($urandom_range(0, 1000));
                    if (k > 0) sp = sb.last_sp;
                    send_req(mk(meas, sp, kp, ki, mode));
                end
                sent += 135;
            end else if (kind < 80) begin
                sp  = MEAS_W'($urandom);
                len = $urandom_range(1, 24);
                for (int k = 0; k < len; k++) begin
                    off = pick_offset();
                    m   = longint'(sp) + off;
                    if (m > 8388607 || m < -8388608) m = longint'(sp) - off;
                    meas = m[MEAS_W-1:0];
                    if ($urandom_range(0, 7) == 0) kp = pick_gain();
                    if ($urandom_range(0, 7) == 0) ki = pick_gain();
                    send_req(mk(meas, sp, kp, ki, pick_mode()));
                end
                sent += len;
            end else begin
                meas = MEAS_W'($urandom);
                sp   = MEAS_W'($urandom);
                send_req(mk(meas, sp, KDIV_W'($urandom), KDIV_W'($urandom), pick_mode()));
                sent++;
            end
        end
    endtask

    initial begin
        logic [CDAT_W-1:0] db, md;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed checks against the reset values of the registers
        send_req(mk(24'sd0, 24'sd0, 16'd256, 16'd1, MODE_PRECISE));
        send_req(mk(24'sd1, 24'sd0, 16'd256, 16'd1, MODE_PRECISE));
        send_req(mk(-24'sd1, 24'sd0, 16'd256, 16'd1, MODE_PRECISE));
        send_req(mk(24'sh7FFFFF, 24'sh800000, 16'd0, 16'd0, MODE_PRECISE));
        send_req(mk(24'sh800000, 24'sh7FFFFF, 16'hFFFF, 16'hFFFF, MODE_SPARE));
        send_req(mk(24'sd100, 24'sd0, 16'd256, 16'd8, MODE_HIGH));
        send_req(mk(-24'sd100, 24'sd0, 16'd256, 16'd8, MODE_HIGH));
        send_req(mk(-24'sd100, 24'sd0, 16'd256, 16'd8, MODE_LOW));
        send_req(mk(24'sd100, 24'sd0, 16'd256, 16'd8, MODE_LOW));
        send_req(mk(24'sd100, 24'sd0, 16'd256, 16'd8, MODE_SPARE));
        send_req(mk(-24'sd3, 24'sd0, 16'd512, 16'hFFFF, MODE_PRECISE));
        repeat (3) send_req(mk(24'sd1010, 24'sd1000, 16'd2560, 16'd4, MODE_PRECISE));
        send_req(mk(-24'sd990, 24'sd1000, 16'd2560, 16'd4, MODE_PRECISE));
        send_req(mk(24'sh555555, 24'shAAAAAA, 16'hAAAA, 16'h5555, MODE_HIGH));
        send_req(mk(24'shAAAAAA, 24'sh555555, 16'h5555, 16'hAAAA, MODE_LOW));
        send_req(mk(24'sd5, 24'sd0, 16'h8000, 16'h7FFF, MODE_PRECISE));
        send_req(mk(-24'sd7, 24'sd0, 16'h0001, 16'h0001, MODE_HIGH));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       begin db = 16'd0;     md = 16'd255; end
                1:       begin db = 16'hFFFF;  md = 16'd0;   end
                2:       begin
                    db = CDAT_W'($urandom_range(0, 200));
                    md = CDAT_W'($urandom_range(1, 254));
                end
                3:       begin db = CDAT_W'($urandom);  md = 16'd255; end
                4:       begin db = 16'd0;     md = 16'd1;   end
                default: begin db = CDAT_W'($urandom_range(0, 2000)); md = 16'd127; end
            endcase
            write_reg(CFG_DEADBAND, db);
            write_reg(CFG_MAX_DRIVE, md);
            case (ph % 4)
                0:       begin in_gap_pct = 0;  out_gap_pct = 0;  end
                1:       begin in_gap_pct = 79; out_gap_pct = 0;  end
                2:       begin in_gap_pct = 0;  out_gap_pct = 79; end
                default: begin in_gap_pct = 22; out_gap_pct = 22; end
            endcase
            run_random(250, ph == 0 || ph == 3);
            drain();
        end

        out_gap_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("drive: %0d expected results never arrived", sb.pending());
            sb.n_err++;
        end
        $display("Covered %0d requests across six deadband/limit settings and four pacing modes",
                 sb.n_req);
        $display("%0d zeroed by deadband or accepted side, %0d accumulator saturations, %0d checked",
                 sb.n_zero, sb.n_sat, sb.n_ok);
        if (sb.n_err == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
